/* design/prz_pkg.sv */
// shared constants, register codes and rounding helpers for the point transform
`timescale 1ns / 1ps
package prz_pkg;

  localparam int COEF_FRAC_BITS = 14;
  localparam int COORD_WIDTH    = 16;
  localparam int ZOOM_FRAC_BITS = 8;
  localparam int DATA_W         = 32;
  localparam int COEF_W         = 16;
  localparam int ROT_REG_W      = 2 * COEF_W;
  localparam int ZOOM_W         = 24;
  localparam int OFFS_W         = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int PROD_W         = DATA_W + COEF_W;
  localparam int SUM_W          = PROD_W + 1;
  localparam int ZPROD_W        = DATA_W + ZOOM_W + 1;
  localparam int NUM_STAGES     = 9;

  localparam logic [ROT_REG_W-1:0] ROT_RESET    = ROT_REG_W'(32'h4000_0000);
  localparam logic [ZOOM_W-1:0]    ZOOM_RESET   = ZOOM_W'(256);
  localparam logic [OFFS_W-1:0]    OFFS_RESET   = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROT_X  = 3'd0,
    CFG_ROT_Y  = 3'd1,
    CFG_ROT_Z  = 3'd2,
    CFG_ZOOM   = 3'd3,
    CFG_OFFS_X = 3'd4,
    CFG_OFFS_Y = 3'd5
  } cfg_idx_e;

  // clamp a wide signed value to the data width
  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [ZPROD_W-1:0] v);
    logic [ZPROD_W-DATA_W:0] top;
    top = v[ZPROD_W-1:DATA_W-1];
    if (&top || ~|top) begin
      return v[DATA_W-1:0];
    end else if (v[ZPROD_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // drop coefficient fraction bits toward zero, then clamp
  function automatic logic signed [DATA_W-1:0] rot_round(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] bias;
    logic signed [SUM_W-1:0] t;
    bias = v[SUM_W-1] ? SUM_W'((64'd1 << COEF_FRAC_BITS) - 64'd1) : '0;
    t    = (v + bias) >>> COEF_FRAC_BITS;
    return sat_data(ZPROD_W'(t));
  endfunction

  // drop zoom fraction bits toward zero, then clamp
  function automatic logic signed [DATA_W-1:0] zoom_round(input logic signed [ZPROD_W-1:0] v);
    logic signed [ZPROD_W-1:0] bias;
    logic signed [ZPROD_W-1:0] t;
    bias = v[ZPROD_W-1] ? ZPROD_W'((64'd1 << ZOOM_FRAC_BITS) - 64'd1) : '0;
    t    = (v + bias) >>> ZOOM_FRAC_BITS;
    return sat_data(t);
  endfunction

  // clamped add of a screen offset
  function automatic logic signed [DATA_W-1:0] offs_add(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [OFFS_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = (DATA_W+1)'(a) + (DATA_W+1)'(b);
    return sat_data(ZPROD_W'(s));
  endfunction

endpackage

/* design/prz_intf.sv */
// handshake channel interfaces for points, screen results and register writes
`timescale 1ns / 1ps
interface prz_point_if import prz_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface prz_screen_if import prz_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] screen_x;
  logic signed [DATA_W-1:0] screen_y;
  logic signed [DATA_W-1:0] depth_z;
  modport source (output valid, screen_x, screen_y, depth_z, input ready);
  modport sink   (input valid, screen_x, screen_y, depth_z, output ready);
endinterface

interface prz_cfg_if import prz_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/point_rotate_zoom_offset.sv */
// point rotate (x, y, z axes), zoom and offset pipeline
//
//   channel   dir  payload                          notes
//   point_i   in   point_x, point_y, point_z        16-bit signed map point
//   screen_o  out  screen_x, screen_y, depth_z      32-bit signed, saturated
//   cfg_i     in   index (3 bits), data (32 bits)   register write, always ready
//
// nine register stages: multiply and sum/round for each of the three rotations,
// then zoom multiply, zoom round and offset add; one point enters every cycle
// while the pipeline advances. the whole pipeline advances together whenever the
// output register is empty or taken, so a stalled sink holds every stage.
// reset clears valid bits and loads the identity rotation, unit zoom, zero offsets.
`timescale 1ns / 1ps
module point_rotate_zoom_offset import prz_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  prz_point_if.sink   point_i,
  prz_screen_if.source screen_o,
  prz_cfg_if.sink     cfg_i
);

  logic [ROT_REG_W-1:0] rot_x_q, rot_y_q, rot_z_q;
  logic [ZOOM_W-1:0]    zoom_q;
  logic [OFFS_W-1:0]    offs_x_q, offs_y_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_x_q  <= ROT_RESET;
      rot_y_q  <= ROT_RESET;
      rot_z_q  <= ROT_RESET;
      zoom_q   <= ZOOM_RESET;
      offs_x_q <= OFFS_RESET;
      offs_y_q <= OFFS_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ROT_X:  rot_x_q  <= cfg_i.data[ROT_REG_W-1:0];
        CFG_ROT_Y:  rot_y_q  <= cfg_i.data[ROT_REG_W-1:0];
        CFG_ROT_Z:  rot_z_q  <= cfg_i.data[ROT_REG_W-1:0];
        CFG_ZOOM:   zoom_q   <= cfg_i.data[ZOOM_W-1:0];
        CFG_OFFS_X: offs_x_q <= cfg_i.data[OFFS_W-1:0];
        CFG_OFFS_Y: offs_y_q <= cfg_i.data[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [COEF_W-1:0] cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;
  logic signed [ZOOM_W:0]   zoom_s;

  assign cos_x  = rot_x_q[ROT_REG_W-1:COEF_W];
  assign sin_x  = rot_x_q[COEF_W-1:0];
  assign cos_y  = rot_y_q[ROT_REG_W-1:COEF_W];
  assign sin_y  = rot_y_q[COEF_W-1:0];
  assign cos_z  = rot_z_q[ROT_REG_W-1:COEF_W];
  assign sin_z  = rot_z_q[COEF_W-1:0];
  assign zoom_s = {1'b0, zoom_q};

  // pipeline control
  logic [NUM_STAGES-1:0] vld_q;
  logic                  adv;

  assign adv           = !vld_q[NUM_STAGES-1] || screen_o.ready;
  assign point_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NUM_STAGES-2:0], point_i.valid};
    end
  end

  logic signed [DATA_W-1:0] in_x, in_y, in_z;

  assign in_x = DATA_W'(point_i.point_x);
  assign in_y = DATA_W'(point_i.point_y);
  assign in_z = DATA_W'(point_i.point_z);

  logic signed [DATA_W-1:0]  s1_x_q;
  logic signed [PROD_W-1:0]  s1_pa_q, s1_pb_q, s1_pc_q, s1_pd_q;
  logic signed [DATA_W-1:0]  s2_x_q, s2_y_q, s2_z_q;
  logic signed [DATA_W-1:0]  s3_y_q;
  logic signed [PROD_W-1:0]  s3_pa_q, s3_pb_q, s3_pc_q, s3_pd_q;
  logic signed [DATA_W-1:0]  s4_x_q, s4_y_q, s4_z_q;
  logic signed [DATA_W-1:0]  s5_z_q;
  logic signed [PROD_W-1:0]  s5_pa_q, s5_pb_q, s5_pc_q, s5_pd_q;
  logic signed [DATA_W-1:0]  s6_x_q, s6_y_q, s6_z_q;
  logic signed [DATA_W-1:0]  s7_z_q;
  logic signed [ZPROD_W-1:0] s7_px_q, s7_py_q;
  logic signed [DATA_W-1:0]  s8_x_q, s8_y_q, s8_z_q;
  logic signed [DATA_W-1:0]  s9_x_q, s9_y_q, s9_z_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // x axis products
      s1_x_q  <= in_x;
      s1_pa_q <= PROD_W'(in_y) * PROD_W'(cos_x);
      s1_pb_q <= PROD_W'(in_z) * PROD_W'(sin_x);
      s1_pc_q <= PROD_W'(in_y) * PROD_W'(sin_x);
      s1_pd_q <= PROD_W'(in_z) * PROD_W'(cos_x);
      // x axis round
      s2_x_q  <= s1_x_q;
      s2_y_q  <= rot_round(SUM_W'(s1_pa_q) - SUM_W'(s1_pb_q));
      s2_z_q  <= rot_round(SUM_W'(s1_pc_q) + SUM_W'(s1_pd_q));
      // y axis products
      s3_y_q  <= s2_y_q;
      s3_pa_q <= PROD_W'(s2_x_q) * PROD_W'(cos_y);
      s3_pb_q <= PROD_W'(s2_z_q) * PROD_W'(sin_y);
      s3_pc_q <= PROD_W'(s2_x_q) * PROD_W'(sin_y);
      s3_pd_q <= PROD_W'(s2_z_q) * PROD_W'(cos_y);
      // y axis round
      s4_y_q  <= s3_y_q;
      s4_x_q  <= rot_round(SUM_W'(s3_pa_q) + SUM_W'(s3_pb_q));
      s4_z_q  <= rot_round(SUM_W'(s3_pd_q) - SUM_W'(s3_pc_q));
      // z axis products
      s5_z_q  <= s4_z_q;
      s5_pa_q <= PROD_W'(s4_x_q) * PROD_W'(cos_z);
      s5_pb_q <= PROD_W'(s4_y_q) * PROD_W'(sin_z);
      s5_pc_q <= PROD_W'(s4_x_q) * PROD_W'(sin_z);
      s5_pd_q <= PROD_W'(s4_y_q) * PROD_W'(cos_z);
      // z axis round
      s6_z_q  <= s5_z_q;
      s6_x_q  <= rot_round(SUM_W'(s5_pa_q) - SUM_W'(s5_pb_q));
      s6_y_q  <= rot_round(SUM_W'(s5_pc_q) + SUM_W'(s5_pd_q));
      // zoom products
      s7_z_q  <= s6_z_q;
      s7_px_q <= ZPROD_W'(s6_x_q) * ZPROD_W'(zoom_s);
      s7_py_q <= ZPROD_W'(s6_y_q) * ZPROD_W'(zoom_s);
      // zoom round
      s8_z_q  <= s7_z_q;
      s8_x_q  <= zoom_round(s7_px_q);
      s8_y_q  <= zoom_round(s7_py_q);
      // offset
      s9_z_q  <= s8_z_q;
      s9_x_q  <= offs_add(s8_x_q, offs_x_q);
      s9_y_q  <= offs_add(s8_y_q, offs_y_q);
    end
  end

  assign screen_o.valid    = vld_q[NUM_STAGES-1];
  assign screen_o.screen_x = s9_x_q;
  assign screen_o.screen_y = s9_y_q;
  assign screen_o.depth_z  = s9_z_q;

endmodule

/* tb/tb_point_rotate_zoom_offset.sv */
// self-checking testbench for the point rotate, zoom and offset pipeline
`timescale 1ns / 1ps
module tb_point_rotate_zoom_offset;
  import prz_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam longint S32_HI = 2147483647;
  localparam longint S32_LO = -S32_HI - 1;
  localparam int NUM_PROBES = 19;
  localparam int RANDOM_PHASES = 10;
  localparam int POINTS_PER_PHASE = 150;
  localparam int LONG_HOLD = 80;

  typedef struct packed {
    logic [DATA_W-1:0] sx;
    logic [DATA_W-1:0] sy;
    logic [DATA_W-1:0] dz;
  } screen_t;

  typedef struct {
    int setting;
    int px, py, pz;
    bit known;
    int ex, ey, ez;
  } probe_row_t;

  logic clk;
  logic rst_n;

  prz_point_if  pt_if ();
  prz_screen_if scr_if ();
  prz_cfg_if    cfg_if ();

  point_rotate_zoom_offset dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .point_i  (pt_if),
    .screen_o (scr_if),
    .cfg_i    (cfg_if)
  );

  logic [ROT_REG_W-1:0]    rot_coef [3];
  logic [ZOOM_W-1:0]       zoom_reg;
  logic signed [OFFS_W-1:0] offs_x;
  logic signed [OFFS_W-1:0] offs_y;

  screen_t pending_screens[$];
  int      mismatch_count = 0;
  int      screens_taken = 0;
  int      send_calm = 0;

  // setting 0 is the reset state and is never written
  logic [31:0] settings [5][6] = '{
    '{32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'h0000_0100, 32'h0, 32'h0},
    '{32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'hFFFF_FFFF, 32'hFFFF_7FFF,
      32'hA5A5_7FFF},
    '{32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 32'hFF00_0000, 32'h1234_8000,
      32'hFFFF_8000},
    '{32'h0000_4000, 32'h0000_C000, 32'h0000_4000, 32'h0000_0200, 32'h0000_7FFF,
      32'h0000_8000},
    '{32'h7FFF_7FFF, 32'hC000_4000, 32'h7FFF_8001, 32'h0000_0080, 32'h0000_0010,
      32'h0000_FFF0}
  };

  probe_row_t probes [NUM_PROBES] = '{
    '{0, 0, 0, 0, 1, 0, 0, 0},
    '{0, 32767, -32768, 32767, 1, 32767, -32768, 32767},
    '{0, -32768, 32767, -32768, 1, -32768, 32767, -32768},
    '{0, -1, 1, -1, 1, -1, 1, -1},
    '{1, 32767, 32767, 32767, 0, 0, 0, 0},
    '{1, -32768, -32768, -32768, 0, 0, 0, 0},
    '{1, 32767, -32768, 32767, 0, 0, 0, 0},
    '{1, -32768, 32767, -32768, 0, 0, 0, 0},
    '{1, 1, -1, 1, 0, 0, 0, 0},
    '{2, 123, -456, 789, 1, -32768, -32768, 789},
    '{2, 32767, 32767, -32768, 1, -32768, -32768, -32768},
    '{2, -32768, -32768, 32767, 1, -32768, -32768, 32767},
    '{3, 100, 200, 300, 0, 0, 0, 0},
    '{3, -32768, 32767, -1, 0, 0, 0, 0},
    '{3, 32767, -32768, 32767, 0, 0, 0, 0},
    '{4, -3, -5, 7, 0, 0, 0, 0},
    '{4, -1, -1, -1, 0, 0, 0, 0},
    '{4, 32767, 32767, 32767, 0, 0, 0, 0},
    '{4, -32768, 0, 32767, 0, 0, 0, 0}
  };

  function automatic longint clamp32(input longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  function automatic longint toward_zero(input longint v, input int sh);
    if (v < 0) return -((-v) >>> sh);
    return v >>> sh;
  endfunction

  function automatic longint rot_sum(input longint a, p, b, q);
    return clamp32(toward_zero(a * p + b * q, COEF_FRAC_BITS));
  endfunction

  function automatic void split_coef(input logic [ROT_REG_W-1:0] w, output longint c,
                                     output longint s);
    logic signed [COEF_W-1:0] hi;
    logic signed [COEF_W-1:0] lo;
    hi = w[ROT_REG_W-1:COEF_W];
    lo = w[COEF_W-1:0];
    c = longint'(hi);
    s = longint'(lo);
  endfunction

  function automatic screen_t project_point(input logic signed [COORD_WIDTH-1:0] px, py, pz);
    longint x, y, z, c, s, nx, ny, nz, zm;
    screen_t r;
    x = longint'(px);
    y = longint'(py);
    z = longint'(pz);
    split_coef(rot_coef[0], c, s);
    ny = rot_sum(y, c, -z, s);
    nz = rot_sum(y, s, z, c);
    y = ny;
    z = nz;
    split_coef(rot_coef[1], c, s);
    nx = rot_sum(x, c, z, s);
    nz = rot_sum(-x, s, z, c);
    x = nx;
    z = nz;
    split_coef(rot_coef[2], c, s);
    nx = rot_sum(x, c, -y, s);
    ny = rot_sum(x, s, y, c);
    x = nx;
    y = ny;
    zm = longint'(zoom_reg);
    x = clamp32(toward_zero(x * zm, ZOOM_FRAC_BITS));
    y = clamp32(toward_zero(y * zm, ZOOM_FRAC_BITS));
    x = clamp32(x + longint'(offs_x));
    y = clamp32(y + longint'(offs_y));
    r.sx = x[DATA_W-1:0];
    r.sy = y[DATA_W-1:0];
    r.dz = z[DATA_W-1:0];
    return r;
  endfunction

  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  function automatic logic [31:0] pick_rotation();
    logic [COEF_W-1:0] c;
    logic [COEF_W-1:0] s;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return ROT_RESET;
      default: begin
        c = 16'($urandom_range(0, 32768)) - 16'd16384;
        s = 16'($urandom_range(0, 32768)) - 16'd16384;
        return {c, s};
      end
    endcase
  endfunction

  function automatic int pick_coord();
    logic signed [COORD_WIDTH-1:0] v;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: return -32768;
        1: return 32767;
        2: return 0;
        default: return -1;
      endcase
    end
    v = COORD_WIDTH'($urandom);
    return int'(v);
  endfunction

  task automatic report_field(input string field, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
    if (mismatch_count < 10) begin
      $display("mismatch on %s: expected %0d, got %0d", field, $signed(want), $signed(got));
    end
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      CFG_ROT_X:  rot_coef[0] = data;
      CFG_ROT_Y:  rot_coef[1] = data;
      CFG_ROT_Z:  rot_coef[2] = data;
      CFG_ZOOM:   zoom_reg = data[ZOOM_W-1:0];
      CFG_OFFS_X: offs_x = data[OFFS_W-1:0];
      CFG_OFFS_Y: offs_y = data[OFFS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [31:0] vals [6]);
    cfg_idx_e idx;
    idx = idx.first();
    repeat (idx.num()) begin
      write_reg(idx, vals[idx]);
      idx = idx.next();
    end
    // unmapped indexes must leave every register alone
    write_reg(CFG_SPARE_A, $urandom);
    write_reg(CFG_SPARE_B, $urandom);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    pt_if.valid <= 1'b0;
    while (pending_screens.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic offer_point(input int px, py, pz, input bit known, input int ex, ey, ez);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_if.valid   <= 1'b1;
    pt_if.point_x <= 16'(px);
    pt_if.point_y <= 16'(py);
    pt_if.point_z <= 16'(pz);
    do @(posedge clk); while (!pt_if.ready);
    if (known) begin
      pending_screens.push_back({32'(ex), 32'(ey), 32'(ez)});
    end else begin
      pending_screens.push_back(project_point(16'(px), 16'(py), 16'(pz)));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("point_rotate_zoom_offset verification failed");
    $finish;
  end

  // receive side with random stalls and two long hold-offs
  initial begin
    int stall;
    int calm;
    screen_t want;
    calm = 0;
    scr_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (screens_taken == 300 || screens_taken == 900) begin
        stall = LONG_HOLD;
      end else begin
        stall = draw_wait(calm);
      end
      if (stall > 0) begin
        scr_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      scr_if.ready <= 1'b1;
      do @(posedge clk); while (!scr_if.valid);
      screens_taken++;
      if (pending_screens.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("unexpected screen request: %0d %0d %0d", scr_if.screen_x,
                   scr_if.screen_y, scr_if.depth_z);
        end
        mismatch_count++;
      end else begin
        want = pending_screens.pop_front();
        if (scr_if.screen_x !== want.sx) report_field("screen_x", want.sx, scr_if.screen_x);
        if (scr_if.screen_y !== want.sy) report_field("screen_y", want.sy, scr_if.screen_y);
        if (scr_if.depth_z !== want.dz) report_field("depth_z", want.dz, scr_if.depth_z);
      end
    end
  end

  initial begin
    int cur;
    logic [31:0] vals [6];
    rst_n         <= 1'b0;
    pt_if.valid   <= 1'b0;
    pt_if.point_x <= '0;
    pt_if.point_y <= '0;
    pt_if.point_z <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= '0;
    cfg_if.data   <= '0;
    rot_coef[0] = ROT_RESET;
    rot_coef[1] = ROT_RESET;
    rot_coef[2] = ROT_RESET;
    zoom_reg = ZOOM_RESET;
    offs_x = OFFS_RESET;
    offs_y = OFFS_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur = 0;
    foreach (probes[i]) begin
      if (probes[i].setting != cur) begin
        settle();
        cur = probes[i].setting;
        load_setting(settings[cur]);
      end
      offer_point(probes[i].px, probes[i].py, probes[i].pz, probes[i].known,
                  probes[i].ex, probes[i].ey, probes[i].ez);
    end

    repeat (RANDOM_PHASES) begin
      settle();
      vals[CFG_ROT_X]  = pick_rotation();
      vals[CFG_ROT_Y]  = pick_rotation();
      vals[CFG_ROT_Z]  = pick_rotation();
      vals[CFG_ZOOM]   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2048);
      vals[CFG_OFFS_X] = $urandom;
      vals[CFG_OFFS_Y] = $urandom;
      load_setting(vals);
      repeat (POINTS_PER_PHASE) begin
        offer_point(pick_coord(), pick_coord(), pick_coord(), 1'b0, 0, 0, 0);
      end
    end

    pt_if.valid <= 1'b0;
    while (pending_screens.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("point_rotate_zoom_offset verification clean");
    end else begin
      $display("point_rotate_zoom_offset verification failed");
    end
    $finish;
  end

endmodule
